@@ rtl/core/wvi_pkg.sv @@
`default_nettype none
package wvi_pkg;

   localparam int NUM_BINS_DEF = 16;

   // request kinds
   localparam logic [1:0] REQ_SAMPLE = 2'd0;
   localparam logic [1:0] REQ_TICK   = 2'd1;
   localparam logic [1:0] REQ_CLEAR  = 2'd2;
   localparam logic [1:0] REQ_NONE   = 2'd3;

   // register indexes
   localparam logic [2:0] CSR_BIN_LEN   = 3'd0;
   localparam logic [2:0] CSR_PRIME_CNT = 3'd1;
   localparam logic [2:0] CSR_MAX_GAP   = 3'd2;
   localparam logic [2:0] CSR_FREEZE    = 3'd3;
   localparam logic [2:0] CSR_TRACK_TC  = 3'd4;
   localparam logic [2:0] CSR_REPRIME   = 3'd5;
   localparam logic [2:0] CSR_MIN_COV   = 3'd6;

   localparam logic [15:0] BIN_LEN_RST   = 16'd320;
   localparam logic [7:0]  PRIME_CNT_RST = 8'd32;
   localparam logic [15:0] MAX_GAP_RST   = 16'd400;
   localparam logic [30:0] FREEZE_RST    = 31'd1966;
   localparam logic [31:0] TRACK_TC_RST  = 32'd30000;
   localparam logic [31:0] REPRIME_RST   = 32'd15000;
   localparam logic [15:0] MIN_COV_RST   = 16'd4000;

   localparam logic [31:0] MS_PER_S   = 32'd1000;
   localparam logic [31:0] GAIN_DIV   = 32'd20;
   localparam logic [15:0] COV_MAX    = 16'hFFFF;
   localparam int          DIV_W      = 48;
   localparam logic [5:0]  DIV_STEPS  = 6'd48;

endpackage
`default_nettype wire

@@ rtl/core/windowed_velocity_integrator.sv @@
// Sequencing: a clear or unused request completes directly; a tick runs the step and
// sum sweeps, one bin per cycle; a sample may also use the shared restoring divider (up
// to two passes per sample).
// Throughput: one request at a time; a new request is taken while the previous
// result still waits on the response side.
// Reset: synchronous, active high; registers to defaults, window and baseline to zero.
`default_nettype none
module windowed_velocity_integrator #(
   parameter int NUM_BINS = wvi_pkg::NUM_BINS_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_type,
   input  wire logic [31:0] req_accel,
   input  wire logic [31:0] req_now_ms,
   input  wire logic        req_track_enable,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [31:0]      rsp_velocity,
   output logic [15:0]      rsp_coverage_ms,
   output logic             rsp_primed,
   output logic             rsp_valid_flag,
   input  wire logic        csr_we,
   input  wire logic [2:0]  csr_index,
   input  wire logic [31:0] csr_wdata
);

   localparam int BW = $clog2(NUM_BINS);
   localparam int VW = 33 + BW;
   localparam int CW = 17 + BW;
   localparam int DW = wvi_pkg::DIV_W;

   typedef enum logic [3:0] {
      S_IDLE, S_DISP, S_ADV, S_MUL, S_IDIV, S_DIV, S_PFIN,
      S_BRD, S_BWR, S_SUM, S_TRK, S_TFIN, S_DONE
   } state_type;

   typedef enum logic [1:0] {OP_PRIME, OP_INTEG, OP_TRACK} div_op_type;

   // configuration
   logic [15:0] bin_len_ff;
   logic [7:0]  psc_ff;
   logic [15:0] max_gap_ff;
   logic [30:0] freeze_ff;
   logic [31:0] tc_ff;
   logic [31:0] reprime_ff;
   logic [15:0] min_cov_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         bin_len_ff <= wvi_pkg::BIN_LEN_RST;
         psc_ff     <= wvi_pkg::PRIME_CNT_RST;
         max_gap_ff <= wvi_pkg::MAX_GAP_RST;
         freeze_ff  <= wvi_pkg::FREEZE_RST;
         tc_ff      <= wvi_pkg::TRACK_TC_RST;
         reprime_ff <= wvi_pkg::REPRIME_RST;
         min_cov_ff <= wvi_pkg::MIN_COV_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            wvi_pkg::CSR_BIN_LEN:   bin_len_ff <= csr_wdata[15:0];
            wvi_pkg::CSR_PRIME_CNT: psc_ff     <= csr_wdata[7:0];
            wvi_pkg::CSR_MAX_GAP:   max_gap_ff <= csr_wdata[15:0];
            wvi_pkg::CSR_FREEZE:    freeze_ff  <= csr_wdata[30:0];
            wvi_pkg::CSR_TRACK_TC:  tc_ff      <= csr_wdata;
            wvi_pkg::CSR_REPRIME:   reprime_ff <= csr_wdata;
            wvi_pkg::CSR_MIN_COV:   min_cov_ff <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   state_type   state_ff;
   div_op_type  div_op_ff;
   logic [1:0]  type_ff;
   logic [31:0] acc_ff;
   logic [31:0] now_ff;
   logic        track_ff;
   logic        neg_ff;
   logic [31:0] mag_ff;
   logic [15:0] dt_ff;
   logic [47:0] prod_ff;
   logic [31:0] elapsed_ff;
   logic [BW-1:0] adv_cnt_ff;
   logic [BW:0]   sum_cnt_ff;
   logic signed [VW-1:0] vsum_ff;
   logic [CW-1:0] csum_ff;
   logic [DW-1:0] div_n_ff;
   logic [31:0]   div_d_ff;
   logic [31:0]   div_rem_ff;
   logic [5:0]    div_cnt_ff;

   logic [BW-1:0] cur_ff;
   logic [31:0]   start_ff;
   logic [31:0]   last_ff;
   logic          have_ff;
   logic [31:0]   base_ff;
   logic [7:0]    pc_ff;
   logic [31:0]   high_ff;
   logic [31:0]   wsum_ff;
   logic [15:0]   wcov_ff;
   logic [NUM_BINS-1:0] bin_vld_ff;

   logic        rsp_valid_ff;
   logic [31:0] rsp_velocity_ff;
   logic [15:0] rsp_coverage_ff;
   logic        rsp_primed_ff;
   logic        rsp_flag_ff;

   // bin store: {velocity, coverage}
   logic [47:0]   mem [NUM_BINS];
   logic [47:0]   rd_ff;
   logic          rdv_ff;
   logic [BW-1:0] raddr;
   logic          mem_we;
   logic [47:0]   mem_wdata;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[cur_ff] <= mem_wdata;
      end
      rd_ff  <= mem[raddr];
      rdv_ff <= bin_vld_ff[raddr];
   end

   logic [32:0]  diff;
   logic [31:0]  diff_mag;
   logic [7:0]   pc_inc;
   logic [15:0]  len;
   logic [31:0]  dt_raw;
   logic [15:0]  dt_clamp;
   logic [BW-1:0] cur_next;
   logic [32:0]  div_sh;
   logic [32:0]  div_sub;
   logic         div_ge;
   logic [48:0]  q_s;
   logic [31:0]  old_v;
   logic [15:0]  old_c;
   logic [49:0]  badd;
   logic [31:0]  bnew_v;
   logic [16:0]  cadd;
   logic [15:0]  bnew_c;
   logic [31:0]  sv;
   logic [15:0]  sc;
   logic signed [VW-1:0] vsum_nx;
   logic [CW-1:0] csum_nx;
   logic [31:0]  wsum_sat;
   logic [15:0]  wcov_sat;
   logic [31:0]  wmag;
   logic [20:0]  dt20;
   logic         primed;

   always_comb begin
      diff     = {acc_ff[31], acc_ff} - {base_ff[31], base_ff};
      diff_mag = diff[32] ? 32'(-diff) : diff[31:0];
      pc_inc   = pc_ff + 8'd1;
      len      = (bin_len_ff == 16'd0) ? 16'd1 : bin_len_ff;
      dt_raw   = now_ff - last_ff;
      dt_clamp = (dt_raw > {16'd0, max_gap_ff}) ? max_gap_ff : dt_raw[15:0];
      cur_next = (cur_ff == BW'(NUM_BINS - 1)) ? '0 : cur_ff + BW'(1);
      div_sh   = {div_rem_ff, div_n_ff[DW-1]};
      div_sub  = div_sh - {1'b0, div_d_ff};
      div_ge   = div_sh >= {1'b0, div_d_ff};
      q_s      = neg_ff ? -{1'b0, div_n_ff} : {1'b0, div_n_ff};
      old_v    = rdv_ff ? rd_ff[47:16] : 32'd0;
      old_c    = rdv_ff ? rd_ff[15:0] : 16'd0;
      badd     = {{18{old_v[31]}}, old_v} + {q_s[48], q_s};
      if (badd[49:31] == {19{badd[49]}}) begin
         bnew_v = badd[31:0];
      end else begin
         bnew_v = badd[49] ? 32'h8000_0000 : 32'h7FFF_FFFF;
      end
      cadd      = {1'b0, old_c} + {1'b0, dt_ff};
      bnew_c    = cadd[16] ? wvi_pkg::COV_MAX : cadd[15:0];
      mem_wdata = {bnew_v, bnew_c};
      mem_we    = (state_ff == S_BWR);
      raddr     = (state_ff == S_SUM && sum_cnt_ff < (BW+1)'(NUM_BINS))
                  ? sum_cnt_ff[BW-1:0] : cur_ff;
      sv        = rdv_ff ? rd_ff[47:16] : 32'd0;
      sc        = rdv_ff ? rd_ff[15:0] : 16'd0;
      vsum_nx   = vsum_ff + VW'($signed(sv));
      csum_nx   = csum_ff + CW'(sc);
      if (vsum_nx[VW-1:31] == {(VW-31){vsum_nx[VW-1]}}) begin
         wsum_sat = vsum_nx[31:0];
      end else begin
         wsum_sat = vsum_nx[VW-1] ? 32'h8000_0000 : 32'h7FFF_FFFF;
      end
      wcov_sat = (|csum_nx[CW-1:16]) ? wvi_pkg::COV_MAX : csum_nx[15:0];
      wmag     = wsum_ff[31] ? (-wsum_ff) : wsum_ff;
      dt20     = {1'b0, dt_ff, 4'b0} + {3'b0, dt_ff, 2'b0};
      primed   = pc_ff >= psc_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         div_op_ff    <= OP_PRIME;
         cur_ff       <= '0;
         start_ff     <= '0;
         last_ff      <= '0;
         have_ff      <= 1'b0;
         base_ff      <= '0;
         pc_ff        <= '0;
         high_ff      <= '0;
         wsum_ff      <= '0;
         wcov_ff      <= '0;
         bin_vld_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && !rsp_stall && state_ff != S_DONE) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  type_ff  <= req_type;
                  acc_ff   <= req_accel;
                  now_ff   <= req_now_ms;
                  track_ff <= req_track_enable;
                  state_ff <= S_DISP;
               end
            end
            S_DISP: begin
               neg_ff     <= diff[32];
               mag_ff     <= diff_mag;
               elapsed_ff <= now_ff - start_ff;
               adv_cnt_ff <= '0;
               unique case (type_ff)
                  wvi_pkg::REQ_SAMPLE: begin
                     if (pc_ff < psc_ff) begin
                        pc_ff      <= pc_inc;
                        last_ff    <= now_ff;
                        have_ff    <= 1'b1;
                        div_n_ff   <= {16'd0, diff_mag};
                        div_d_ff   <= {24'd0, pc_inc};
                        div_rem_ff <= '0;
                        div_cnt_ff <= wvi_pkg::DIV_STEPS;
                        div_op_ff  <= OP_PRIME;
                        state_ff   <= S_DIV;
                     end else if (!have_ff) begin
                        last_ff  <= now_ff;
                        have_ff  <= 1'b1;
                        state_ff <= S_DONE;
                     end else begin
                        last_ff  <= now_ff;
                        dt_ff    <= dt_clamp;
                        state_ff <= (dt_raw == 32'd0) ? S_DONE : S_ADV;
                     end
                  end
                  wvi_pkg::REQ_TICK: state_ff <= S_ADV;
                  wvi_pkg::REQ_CLEAR: begin
                     bin_vld_ff <= '0;
                     cur_ff     <= '0;
                     start_ff   <= now_ff;
                     wsum_ff    <= '0;
                     wcov_ff    <= '0;
                     state_ff   <= S_DONE;
                  end
                  default: state_ff <= S_DONE;
               endcase
            end
            S_ADV: begin
               if (elapsed_ff >= {16'd0, len} && adv_cnt_ff == BW'(NUM_BINS - 1)) begin
                  bin_vld_ff <= '0;
                  cur_ff     <= '0;
                  start_ff   <= now_ff;
                  elapsed_ff <= '0;
               end else if (elapsed_ff >= {16'd0, len}) begin
                  cur_ff               <= cur_next;
                  bin_vld_ff[cur_next] <= 1'b0;
                  start_ff             <= start_ff + {16'd0, len};
                  elapsed_ff           <= elapsed_ff - {16'd0, len};
                  adv_cnt_ff           <= adv_cnt_ff + BW'(1);
               end else if (type_ff == wvi_pkg::REQ_TICK) begin
                  sum_cnt_ff <= '0;
                  vsum_ff    <= '0;
                  csum_ff    <= '0;
                  state_ff   <= S_SUM;
               end else begin
                  state_ff <= S_MUL;
               end
            end
            S_MUL: begin
               prod_ff  <= mag_ff * dt_ff;
               state_ff <= S_IDIV;
            end
            S_IDIV: begin
               div_n_ff   <= prod_ff;
               div_d_ff   <= wvi_pkg::MS_PER_S;
               div_rem_ff <= '0;
               div_cnt_ff <= wvi_pkg::DIV_STEPS;
               div_op_ff  <= OP_INTEG;
               state_ff   <= S_DIV;
            end
            S_DIV: begin
               if (div_ge) begin
                  div_rem_ff <= div_sub[31:0];
               end else begin
                  div_rem_ff <= div_sh[31:0];
               end
               div_n_ff   <= {div_n_ff[DW-2:0], div_ge};
               div_cnt_ff <= div_cnt_ff - 6'd1;
               if (div_cnt_ff == 6'd1) begin
                  unique case (div_op_ff)
                     OP_PRIME: state_ff <= S_PFIN;
                     OP_INTEG: state_ff <= S_BRD;
                     OP_TRACK: state_ff <= S_TFIN;
                     default:  state_ff <= S_DONE;
                  endcase
               end
            end
            S_PFIN: begin
               base_ff <= base_ff + q_s[31:0];
               if (pc_ff >= psc_ff) begin
                  bin_vld_ff <= '0;
                  cur_ff     <= '0;
                  start_ff   <= now_ff;
                  wsum_ff    <= '0;
                  wcov_ff    <= '0;
               end
               state_ff <= S_DONE;
            end
            S_BRD: state_ff <= S_BWR;
            S_BWR: begin
               bin_vld_ff[cur_ff] <= 1'b1;
               sum_cnt_ff         <= '0;
               vsum_ff            <= '0;
               csum_ff            <= '0;
               state_ff           <= S_SUM;
            end
            S_SUM: begin
               sum_cnt_ff <= sum_cnt_ff + (BW+1)'(1);
               if (sum_cnt_ff != '0) begin
                  vsum_ff <= vsum_nx;
                  csum_ff <= csum_nx;
               end
               if (sum_cnt_ff == (BW+1)'(NUM_BINS)) begin
                  wsum_ff  <= wsum_sat;
                  wcov_ff  <= wcov_sat;
                  state_ff <= (type_ff == wvi_pkg::REQ_TICK) ? S_DONE : S_TRK;
               end
            end
            S_TRK: begin
               if (track_ff && wmag < {1'b0, freeze_ff}) begin
                  high_ff    <= '0;
                  div_rem_ff <= '0;
                  div_cnt_ff <= wvi_pkg::DIV_STEPS;
                  div_op_ff  <= OP_TRACK;
                  if (tc_ff == 32'd0 || {11'd0, dt20} > tc_ff) begin
                     div_n_ff <= {16'd0, mag_ff};
                     div_d_ff <= wvi_pkg::GAIN_DIV;
                  end else begin
                     div_n_ff <= prod_ff;
                     div_d_ff <= tc_ff;
                  end
                  state_ff <= S_DIV;
               end else begin
                  if (!track_ff) begin
                     high_ff <= '0;
                  end else if (high_ff == 32'd0) begin
                     high_ff <= now_ff;
                  end else if (now_ff - high_ff > reprime_ff) begin
                     pc_ff      <= '0;
                     high_ff    <= '0;
                     bin_vld_ff <= '0;
                     cur_ff     <= '0;
                     start_ff   <= now_ff;
                     wsum_ff    <= '0;
                     wcov_ff    <= '0;
                  end
                  state_ff <= S_DONE;
               end
            end
            S_TFIN: begin
               base_ff  <= base_ff + q_s[31:0];
               state_ff <= S_DONE;
            end
            S_DONE: begin
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_valid_ff    <= 1'b1;
                  rsp_velocity_ff <= wsum_ff;
                  rsp_coverage_ff <= wcov_ff;
                  rsp_primed_ff   <= primed;
                  rsp_flag_ff     <= primed && (wcov_ff >= min_cov_ff);
                  state_ff        <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_stall       = (state_ff != S_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_velocity    = rsp_velocity_ff;
   assign rsp_coverage_ms = rsp_coverage_ff;
   assign rsp_primed      = rsp_primed_ff;
   assign rsp_valid_flag  = rsp_flag_ff;

`ifndef SYNTHESIS
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == S_DISP))
      else $error("request accepted but sequencer did not start");

   a_div_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV) |-> (div_cnt_ff != 6'd0))
      else $error("divider running with zero step count");

   a_done_loads: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && !(rsp_valid_ff && rsp_stall)) |=>
      (rsp_valid_ff && state_ff == S_IDLE))
      else $error("result not loaded on completion");

   a_bin_written: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_BWR) |=> bin_vld_ff[$past(cur_ff)])
      else $error("written bin not marked valid");
`endif

endmodule
`default_nettype wire
